@@ design/toroidal_life_like_automaton_assert.svh @@
// assertion macros for the toroidal life-like automaton
`ifndef TOROIDAL_LIFE_LIKE_AUTOMATON_ASSERT_SVH
`define TOROIDAL_LIFE_LIKE_AUTOMATON_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define TLLA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tlla: same-cycle check failed");
// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define TLLA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tlla: next-cycle check failed");
`else
`define TLLA_ASSERT_IMP(lbl, ante, cons)
`define TLLA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ design/tlla_pkg.sv @@
// shared constants, types and helpers of the toroidal life-like automaton
package tlla_pkg;

    // built board size
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;

    // index and dimension widths
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int WDIM_W    = $clog2(MAX_WIDTH + 1);
    localparam int HDIM_W    = $clog2(MAX_HEIGHT + 1);
    localparam int ADDR_W    = ROW_W + 1;
    localparam int MEM_DEPTH = 2 ** ADDR_W;

    // field widths
    localparam int COORD_W    = 16;
    localparam int CMD_W      = 2;
    localparam int DIM_CFG_W  = 7;
    localparam int MASK_W     = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int CNT_W      = $clog2(COORD_W + 1);

    // neighbor count width, indexes the rule masks
    localparam int NB_W       = $clog2(MASK_W);

    // register reset values
    localparam logic [DIM_CFG_W-1:0] WIDTH_RST  = DIM_CFG_W'(64);
    localparam logic [DIM_CFG_W-1:0] HEIGHT_RST = DIM_CFG_W'(64);
    localparam logic [MASK_W-1:0]    STAY_RST   = MASK_W'(12);
    localparam logic [MASK_W-1:0]    BORN_RST   = MASK_W'(8);

    typedef logic [MAX_WIDTH-1:0] t_row;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_STEP  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_STAY   = 2'd2,
        CFG_BORN   = 2'd3
    } t_cfg_idx;

    // which board row the read port fetches
    typedef enum logic [1:0] {
        ROW_COORD,
        ROW_UP,
        ROW_MID,
        ROW_DOWN
    } t_row_sel;

    // which window register takes the read data
    typedef enum logic [1:0] {
        WIN_NONE,
        WIN_ABOVE,
        WIN_CENTER,
        WIN_BELOW
    } t_win_ld;

    // what the write port does
    typedef enum logic [1:0] {
        WR_NONE,
        WR_CLEAR,
        WR_CELL,
        WR_ROW
    } t_wr_kind;

    // controller to datapath
    typedef struct packed {
        logic     take;
        logic     wrap_start;
        logic     rd_en;
        t_row_sel rd_sel;
        t_win_ld  win_ld;
        t_wr_kind wr_kind;
        logic     row_inc;
        logic     flip;
        logic     cell_cap;
        logic     res_load;
        t_cmd     res_kind;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic wrap_busy;
        logic clr_last;
        logic row_last;
        logic res_free;
    } t_dp_stat;

    // width in use: zero reads as one, above the build limit reads as the limit
    function automatic logic [WDIM_W-1:0] eff_width(logic [DIM_CFG_W-1:0] v);
        logic [WDIM_W-1:0] r;
        if (v == '0) begin
            r = WDIM_W'(1);
        end else if (int'(v) > MAX_WIDTH) begin
            r = WDIM_W'(MAX_WIDTH);
        end else begin
            r = WDIM_W'(v);
        end
        return r;
    endfunction

    // height in use, same clamping
    function automatic logic [HDIM_W-1:0] eff_height(logic [DIM_CFG_W-1:0] v);
        logic [HDIM_W-1:0] r;
        if (v == '0) begin
            r = HDIM_W'(1);
        end else if (int'(v) > MAX_HEIGHT) begin
            r = HDIM_W'(MAX_HEIGHT);
        end else begin
            r = HDIM_W'(v);
        end
        return r;
    endfunction

endpackage

@@ design/tlla_cmd_if.sv @@
// request channel: command and cell coordinates
interface tlla_cmd_if
    import tlla_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          cmd;
    logic signed [COORD_W-1:0] x_pos;
    logic signed [COORD_W-1:0] y_pos;
    logic                      cell_in;

    modport source (output valid, output cmd, output x_pos, output y_pos,
                    output cell_in, input ready);
    modport sink   (input valid, input cmd, input x_pos, input y_pos,
                    input cell_in, output ready);
endinterface

@@ design/tlla_res_if.sv @@
// result channel: cell value and completed command code
interface tlla_res_if
    import tlla_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             cell_out;
    logic [CMD_W-1:0] done_kind;

    modport source (output valid, output cell_out, output done_kind, input ready);
    modport sink   (input valid, input cell_out, input done_kind, output ready);
endinterface

@@ design/tlla_wrap.sv @@
// iterative floored modulo of both signed coordinates, one quotient bit per cycle
module tlla_wrap
    import tlla_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [COORD_W-1:0] i_x_pos,
    input  logic signed [COORD_W-1:0] i_y_pos,
    input  logic [WDIM_W-1:0]         i_width,
    input  logic [HDIM_W-1:0]         i_height,
    output logic                      o_busy,
    output logic [COL_W-1:0]          o_x_idx,
    output logic [ROW_W-1:0]          o_y_idx
);

    logic                r_busy;
    logic [CNT_W-1:0]    r_cnt;
    logic [COORD_W-1:0]  r_xmag;
    logic [COORD_W-1:0]  r_ymag;
    logic                r_xneg;
    logic                r_yneg;
    logic [COL_W-1:0]    r_xrem;
    logic [ROW_W-1:0]    r_yrem;

    logic [COL_W:0]      x_trial;
    logic [COL_W:0]      x_div;
    logic [COL_W:0]      x_sub;
    logic [ROW_W:0]      y_trial;
    logic [ROW_W:0]      y_div;
    logic [ROW_W:0]      y_sub;
    logic [WDIM_W-1:0]   x_flip;
    logic [HDIM_W-1:0]   y_flip;
    logic [COL_W-1:0]    n_xrem;
    logic [ROW_W-1:0]    n_yrem;
    logic [COL_W-1:0]    x_fixed;
    logic [ROW_W-1:0]    y_fixed;

    // one restoring step on each remainder
    always_comb begin
        x_trial = {r_xrem, r_xmag[COORD_W-1]};
        x_div   = (COL_W + 1)'(i_width);
        x_sub   = (x_trial >= x_div) ? (x_trial - x_div) : x_trial;
        n_xrem  = x_sub[COL_W-1:0];
        y_trial = {r_yrem, r_ymag[COORD_W-1]};
        y_div   = (ROW_W + 1)'(i_height);
        y_sub   = (y_trial >= y_div) ? (y_trial - y_div) : y_trial;
        n_yrem  = y_sub[ROW_W-1:0];
    end

    // negative coordinate with nonzero remainder folds to size minus remainder
    always_comb begin
        x_flip  = i_width - WDIM_W'(r_xrem);
        y_flip  = i_height - HDIM_W'(r_yrem);
        x_fixed = (r_xneg && (r_xrem != '0)) ? x_flip[COL_W-1:0] : r_xrem;
        y_fixed = (r_yneg && (r_yrem != '0)) ? y_flip[ROW_W-1:0] : r_yrem;
    end

    // step counter: COORD_W steps, then the fold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(COORD_W);
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    // magnitude shift registers and remainders
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_xneg <= i_x_pos[COORD_W-1];
            r_yneg <= i_y_pos[COORD_W-1];
            r_xmag <= i_x_pos[COORD_W-1] ? COORD_W'(~i_x_pos + 1'b1) : COORD_W'(i_x_pos);
            r_ymag <= i_y_pos[COORD_W-1] ? COORD_W'(~i_y_pos + 1'b1) : COORD_W'(i_y_pos);
            r_xrem <= '0;
            r_yrem <= '0;
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_xmag <= {r_xmag[COORD_W-2:0], 1'b0};
                r_ymag <= {r_ymag[COORD_W-2:0], 1'b0};
                r_xrem <= n_xrem;
                r_yrem <= n_yrem;
            end else begin
                r_xrem <= x_fixed;
                r_yrem <= y_fixed;
            end
        end
    end

    assign o_busy  = r_busy;
    assign o_x_idx = r_xrem;
    assign o_y_idx = r_yrem;

endmodule

@@ design/tlla_ctrl.sv @@
// command sequencer: clearing pass, cell access and generation sweep
module tlla_ctrl
    import tlla_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_cmd     i_in_cmd,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WRAP,
        S_CELL_WR,
        S_CELL_RD,
        S_CELL_CAP,
        S_UP,
        S_MID,
        S_DOWN,
        S_LOAD,
        S_ROW_WR,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   r_op;

    // state and latched command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_op    <= CMD_NONE;
        end else begin
            r_state <= n_state;
            if ((r_state == S_IDLE) && i_in_valid) begin
                r_op <= i_in_cmd;
            end
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // next state and datapath commands
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.res_kind = r_op;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.wr_kind = WR_CLEAR;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    unique case (i_in_cmd)
                        CMD_WRITE, CMD_READ: begin
                            o_cmd.wrap_start = 1'b1;
                            n_state          = S_WRAP;
                        end
                        CMD_STEP: n_state = S_UP;
                        CMD_NONE: n_state = S_IDLE;
                    endcase
                end
            end
            S_WRAP: begin
                if (!i_stat.wrap_busy) begin
                    n_state = (r_op == CMD_WRITE) ? S_CELL_WR : S_CELL_RD;
                end
            end
            S_CELL_WR: begin
                o_cmd.wr_kind = WR_CELL;
                n_state       = S_FINISH;
            end
            S_CELL_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = ROW_COORD;
                n_state      = S_CELL_CAP;
            end
            S_CELL_CAP: begin
                o_cmd.cell_cap = 1'b1;
                n_state        = S_FINISH;
            end
            S_UP: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = ROW_UP;
                n_state      = S_MID;
            end
            S_MID: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = ROW_MID;
                o_cmd.win_ld = WIN_ABOVE;
                n_state      = S_DOWN;
            end
            S_DOWN: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = ROW_DOWN;
                o_cmd.win_ld = WIN_CENTER;
                n_state      = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.win_ld = WIN_BELOW;
                n_state      = S_ROW_WR;
            end
            S_ROW_WR: begin
                o_cmd.wr_kind = WR_ROW;
                if (i_stat.row_last) begin
                    o_cmd.flip = 1'b1;
                    n_state    = S_FINISH;
                end else begin
                    o_cmd.row_inc = 1'b1;
                    n_state       = S_UP;
                end
            end
            S_FINISH: begin
                if (i_stat.res_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

endmodule

@@ design/tlla_dp.sv @@
// board memory, row window, rule lanes and result register
module tlla_dp
    import tlla_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    output t_dp_stat                  o_stat,
    input  logic signed [COORD_W-1:0] i_x_pos,
    input  logic signed [COORD_W-1:0] i_y_pos,
    input  logic                      i_cell_in,
    input  logic [WDIM_W-1:0]         i_width,
    input  logic [HDIM_W-1:0]         i_height,
    input  logic [MASK_W-1:0]         i_stay_mask,
    input  logic [MASK_W-1:0]         i_born_mask,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic                      o_cell_out,
    output logic [CMD_W-1:0]          o_done_kind
);

    // both boards in one memory, board select in the top address bit
    t_row r_mem [MEM_DEPTH];
    t_row r_rd_data;
    t_row r_above;
    t_row r_center;
    t_row r_below;

    logic [ROW_W-1:0]  r_row;
    logic              r_active;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_val;
    logic              r_cell_cap;
    logic              r_out_valid;
    logic              r_out_cell;
    logic [CMD_W-1:0]  r_out_kind;

    logic              wrap_busy;
    logic [COL_W-1:0]  x_idx;
    logic [ROW_W-1:0]  y_idx;

    logic [WDIM_W-1:0] w_m1;
    logic [HDIM_W-1:0] h_m1;
    logic [COL_W-1:0]  col_last;
    logic [ROW_W-1:0]  row_last;
    logic [ROW_W-1:0]  row_up;
    logic [ROW_W-1:0]  row_dn;
    logic [ROW_W-1:0]  rd_row;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    t_row              wr_data;
    t_row              wr_mask;
    t_row              row_mask;
    t_row              new_row;

    // left neighbor of every column, column zero wraps to the last column in use
    function automatic t_row left_of(t_row r, logic [COL_W-1:0] last);
        t_row v;
        v = {r[MAX_WIDTH-2:0], r[last]};
        return v;
    endfunction

    // right neighbor of every column, the last column in use wraps to column zero
    function automatic t_row right_of(t_row r, logic [COL_W-1:0] last);
        t_row v;
        v       = {r[0], r[MAX_WIDTH-1:1]};
        v[last] = r[0];
        return v;
    endfunction

    tlla_wrap u_wrap (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.wrap_start),
        .i_x_pos  (i_x_pos),
        .i_y_pos  (i_y_pos),
        .i_width  (i_width),
        .i_height (i_height),
        .o_busy   (wrap_busy),
        .o_x_idx  (x_idx),
        .o_y_idx  (y_idx)
    );

    // last column and row in use, wrapped row neighbors
    always_comb begin
        w_m1     = i_width - WDIM_W'(1);
        h_m1     = i_height - HDIM_W'(1);
        col_last = w_m1[COL_W-1:0];
        row_last = h_m1[ROW_W-1:0];
        row_up   = (r_row == '0) ? row_last : (r_row - ROW_W'(1));
        row_dn   = (r_row == row_last) ? '0 : (r_row + ROW_W'(1));
    end

    // read address
    always_comb begin
        unique case (i_cmd.rd_sel)
            ROW_COORD: rd_row = y_idx;
            ROW_UP:    rd_row = row_up;
            ROW_MID:   rd_row = r_row;
            ROW_DOWN:  rd_row = row_dn;
        endcase
        rd_addr = {r_active, rd_row};
    end

    // rule lanes, one per column
    always_comb begin
        t_row             al;
        t_row             ar;
        t_row             cl;
        t_row             cr;
        t_row             bl;
        t_row             br;
        logic [NB_W-1:0]  cnt;
        al = left_of(r_above, col_last);
        ar = right_of(r_above, col_last);
        cl = left_of(r_center, col_last);
        cr = right_of(r_center, col_last);
        bl = left_of(r_below, col_last);
        br = right_of(r_below, col_last);
        for (int i = 0; i < MAX_WIDTH; i++) begin
            cnt = NB_W'(al[i]) + NB_W'(r_above[i]) + NB_W'(ar[i])
                + NB_W'(cl[i]) + NB_W'(cr[i])
                + NB_W'(bl[i]) + NB_W'(r_below[i]) + NB_W'(br[i]);
            new_row[i]  = r_center[i] ? i_stay_mask[cnt] : i_born_mask[cnt];
            row_mask[i] = (WDIM_W'(i) < i_width);
        end
    end

    // write port select
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_clr_addr;
        wr_data = '0;
        wr_mask = '1;
        unique case (i_cmd.wr_kind)
            WR_NONE: wr_en = 1'b0;
            WR_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_addr;
            end
            WR_CELL: begin
                wr_en   = 1'b1;
                wr_addr = {r_active, y_idx};
                wr_data = {MAX_WIDTH{r_val}};
                wr_mask = t_row'(1) << x_idx;
            end
            WR_ROW: begin
                wr_en   = 1'b1;
                wr_addr = {~r_active, r_row};
                wr_data = new_row;
                wr_mask = row_mask;
            end
        endcase
    end

    // board memory with per-bit write enables
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            for (int i = 0; i < MAX_WIDTH; i++) begin
                if (wr_mask[i]) begin
                    r_mem[wr_addr][i] <= wr_data[i];
                end
            end
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_clr_addr  <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.wr_kind == WR_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (i_cmd.take) begin
                r_row <= '0;
            end else if (i_cmd.row_inc) begin
                r_row <= r_row + ROW_W'(1);
            end
            if (i_cmd.flip) begin
                r_active <= ~r_active;
            end
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // window, request data and result payload
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.win_ld)
            WIN_NONE:   r_above  <= r_above;
            WIN_ABOVE:  r_above  <= r_rd_data;
            WIN_CENTER: r_center <= r_rd_data;
            WIN_BELOW:  r_below  <= r_rd_data;
        endcase
        if (i_cmd.take) begin
            r_val <= i_cell_in;
        end
        if (i_cmd.cell_cap) begin
            r_cell_cap <= r_rd_data[x_idx];
        end
        if (i_cmd.res_load) begin
            r_out_cell <= (i_cmd.res_kind == CMD_READ) & r_cell_cap;
            r_out_kind <= i_cmd.res_kind;
        end
    end

    // status
    always_comb begin
        o_stat.wrap_busy = wrap_busy;
        o_stat.clr_last  = &r_clr_addr;
        o_stat.row_last  = (r_row == row_last);
        o_stat.res_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_cell_out  = r_out_cell;
    assign o_done_kind = r_out_kind;

endmodule

@@ design/toroidal_life_like_automaton.sv @@
// top level of the toroidal life-like automaton
// Toroidal life-like automaton on a board of up to MAX_WIDTH x MAX_HEIGHT cells
// (64 x 64), held twice (current and next generation) in one row-wide memory of
// 2 x MAX_HEIGHT rows with one read and one write port. After reset a clearing
// pass writes every row of both boards, during which no request is accepted;
// configuration writes are taken at any time the block is idle. One request is
// in work at a time, and the next is accepted while the previous result still
// waits on the output register. For a write or a read request the signed
// coordinates are reduced modulo width and height one bit per cycle (16 steps
// plus a fold). For an advance request each row needs three reads of the single
// row port (row above, the row, row below), a window load and one row-wide write
// of the lanes in use. Command code 3 is accepted and gives no result.
module toroidal_life_like_automaton
    import tlla_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tlla_cmd_if.sink              i_cmd,
    tlla_res_if.source            o_res
);

    logic [DIM_CFG_W-1:0] r_width;
    logic [DIM_CFG_W-1:0] r_height;
    logic [MASK_W-1:0]    r_stay;
    logic [MASK_W-1:0]    r_born;

    logic [WDIM_W-1:0]    width_use;
    logic [HDIM_W-1:0]    height_use;
    t_dp_cmd              dp_cmd;
    t_dp_stat             dp_stat;
    logic                 in_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_stay   <= STAY_RST;
            r_born   <= BORN_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_WIDTH:  r_width  <= i_cfg_data[DIM_CFG_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[DIM_CFG_W-1:0];
                CFG_STAY:   r_stay   <= i_cfg_data[MASK_W-1:0];
                CFG_BORN:   r_born   <= i_cfg_data[MASK_W-1:0];
            endcase
        end
    end

    // dimensions in use
    assign width_use  = eff_width(r_width);
    assign height_use = eff_height(r_height);

    tlla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .i_in_cmd   (t_cmd'(i_cmd.cmd)),
        .o_in_ready (in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    tlla_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_x_pos     (i_cmd.x_pos),
        .i_y_pos     (i_cmd.y_pos),
        .i_cell_in   (i_cmd.cell_in),
        .i_width     (width_use),
        .i_height    (height_use),
        .i_stay_mask (r_stay),
        .i_born_mask (r_born),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_cell_out  (o_res.cell_out),
        .o_done_kind (o_res.done_kind)
    );

    assign i_cmd.ready = in_ready;

    // checks
`include "toroidal_life_like_automaton_assert.svh"

    // the coordinate unit is never left running when a new request can come in
    `TLLA_ASSERT_IMP(a_ready_wrap_idle, i_cmd.ready, !dp_stat.wrap_busy)
    // only a read result carries a live cell
    `TLLA_ASSERT_IMP(a_cell_only_read, o_res.valid && o_res.cell_out, o_res.done_kind == CMD_READ)
    // an unused command code leaves the block ready
    `TLLA_ASSERT_NXT(a_skip_stays_ready, i_cmd.valid && i_cmd.ready && (i_cmd.cmd == CMD_NONE), i_cmd.ready)

endmodule
